// ===== hw/rtl/aprq_pkg.sv =====
// Shared constants, codes and types for the aging priority ready queue.
// No dependencies; imported by every other file of the block but aprq_ram.
`timescale 1ns / 1ps
`default_nettype none
package aprq_pkg;

   localparam int NUM_PROC   = 64;
   localparam int QDEPTH     = 64;
   localparam int WAIT_BITS  = 16;
   localparam int PID_W      = $clog2(NUM_PROC);
   localparam int IDX_W      = $clog2(QDEPTH);
   localparam int CNT_W      = $clog2(QDEPTH + 1);
   localparam int KEY_W      = 5;
   localparam int BASE_W     = 4;
   localparam int SUM_W      = 32;
   localparam int ECNT_W     = 16;

   localparam logic [WAIT_BITS-1:0] WAIT_MAX   = '1;
   localparam logic [BASE_W-1:0]    BASE_LIMIT = 4'd15;
   localparam logic [KEY_W-1:0]     KEY_MAX    = '1;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [2:0] CMD_HOLD = 3'd0;
   localparam logic [2:0] CMD_PUSH = 3'd1;
   localparam logic [2:0] CMD_POP  = 3'd2;
   localparam logic [2:0] CMD_TICK = 3'd3;
   localparam logic [2:0] CMD_SORT = 3'd4;

   // one queue entry with its private copy of the process record
   typedef struct packed {
      logic                 valid;
      logic [PID_W-1:0]     pid;
      logic [WAIT_BITS-1:0] wait_cnt;
      logic [KEY_W-1:0]     cur;
      logic [BASE_W-1:0]    base;
      logic [CNT_W-1:0]     dups;
   } cell_type;

   typedef struct packed {
      logic [2:0]           cmd;
      logic [PID_W-1:0]     pid;
      logic [BASE_W-1:0]    bp;
      logic [WAIT_BITS-1:0] lk_wait;
      logic [CNT_W-1:0]     lk_dups;
      logic [WAIT_BITS-1:0] thr;
      logic                 phase;
      logic [CNT_W-1:0]     count;
      logic [PID_W-1:0]     pop_pid;
   } ctl_type;

   typedef struct packed {
      logic [ECNT_W-1:0]    entries;
      logic [SUM_W-1:0]     sum;
      logic [WAIT_BITS-1:0] wmax;
      logic [WAIT_BITS-1:0] wmin;
   } stat_type;

   localparam int STAT_W = $bits(stat_type);
   localparam stat_type STAT_RESET = '{entries: '0, sum: '0, wmax: '0, wmin: WAIT_MAX};

endpackage
`default_nettype wire

// ===== hw/rtl/aprq_req_if.sv =====
// Request channel: valid/ready handshake with one queue command word.
// Depends on aprq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface aprq_req_if import aprq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [PID_W-1:0]  process_id;
   logic [BASE_W-1:0] base_priority;

   modport source (output valid, opcode, process_id, base_priority, input ready);
   modport sink   (input valid, opcode, process_id, base_priority, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aprq_rsp_if.sv =====
// Response channel: valid/ready handshake with one result word.
// Depends on aprq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface aprq_rsp_if import aprq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [PID_W-1:0]     cpu_process;
   logic [WAIT_BITS-1:0] wait_time;
   logic [WAIT_BITS-1:0] wait_min;
   logic [WAIT_BITS-1:0] wait_max;
   logic [SUM_W-1:0]     wait_sum;
   logic [ECNT_W-1:0]    wait_count;
   logic [CNT_W-1:0]     queue_length;

   modport source (output valid, status, cpu_process, wait_time, wait_min, wait_max,
                   wait_sum, wait_count, queue_length, input ready);
   modport sink   (input valid, status, cpu_process, wait_time, wait_min, wait_max,
                   wait_sum, wait_count, queue_length, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aging_priority_ready_queue_unit.sv =====
// Top level of the aging priority ready queue: cell row, sequencer, statistics RAM.
// Depends on aprq_pkg, aprq_req_if, aprq_rsp_if, aprq_ram and aprq_cell.
//
//   channel | direction | word
//   req     | in        | opcode, process_id, base_priority
//   rsp     | out       | status, cpu_process, wait_*, queue_length
//   csr     | in        | aging_threshold, write only
//
// Pop runs the pop and done states; push runs look, push, odd-even sort phases of the
// cell row and done; tick runs tick, sort phases and done; other words go to done.
// Synchronous reset clears the row, the counters and the statistics valid bits.
// A finished word waits in the response register; a stalled response holds the
// sequencer in its last state, and one word is in work at a time.
`timescale 1ns / 1ps
`default_nettype none
module aging_priority_ready_queue_unit import aprq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   aprq_req_if.sink                  req_port,
   aprq_rsp_if.source                rsp_port,
   input  wire logic                 csr_write_enable,
   input  wire logic [WAIT_BITS-1:0] csr_write_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_PUSH = 3'd2;
   localparam logic [2:0] S_TICK = 3'd3;
   localparam logic [2:0] S_POP  = 3'd4;
   localparam logic [2:0] S_SORT = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [PID_W-1:0]     pid_ff;
   logic [BASE_W-1:0]    bp_ff;
   logic [WAIT_BITS-1:0] thr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 phase_ff, phase_in, quiet_ff, quiet_in;
   logic [WAIT_BITS-1:0] lk_wait_ff;
   logic [CNT_W-1:0]     lk_dups_ff;
   logic [WAIT_BITS+CNT_W-1:0] lk_or;

   logic [1:0]           res_status_ff;
   logic [PID_W-1:0]     res_pid_ff;
   logic [WAIT_BITS-1:0] res_wait_ff, res_min_ff, res_max_ff;
   logic [SUM_W-1:0]     res_sum_ff;
   logic [ECNT_W-1:0]    res_cnt_ff;

   logic                 rsp_valid_ff;
   logic                 accept, load_rsp, any_swap;

   cell_type             cells [QDEPTH];
   logic [QDEPTH-1:0]    sw;
   logic [QDEPTH-1:0]    cell_vld;
   ctl_type              ctl;

   logic [NUM_PROC-1:0]  stat_vld_ff;
   logic                 rd_vld_ff;
   logic                 ram_we;
   logic [PID_W-1:0]     ram_raddr, ram_waddr;
   logic [STAT_W-1:0]    ram_rdata;
   stat_type             st, st_wr;
   logic [SUM_W:0]       sum_ext;
   logic [WAIT_BITS-1:0] head_wait;

   assign accept         = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);
   assign load_rsp       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_port.ready);
   assign head_wait      = cells[0].wait_cnt;

   // ---- cell row ----
   assign ctl.cmd     = (state_ff == S_PUSH) ? CMD_PUSH :
                        (state_ff == S_POP)  ? CMD_POP  :
                        (state_ff == S_TICK) ? CMD_TICK :
                        (state_ff == S_SORT) ? CMD_SORT : CMD_HOLD;
   assign ctl.pid     = pid_ff;
   assign ctl.bp      = bp_ff;
   assign ctl.lk_wait = lk_wait_ff;
   assign ctl.lk_dups = lk_dups_ff;
   assign ctl.thr     = thr_ff;
   assign ctl.phase   = phase_ff;
   assign ctl.count   = count_ff;
   assign ctl.pop_pid = cells[0].pid;

   for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
      cell_type lft, rgt;
      logic     swl;
      if (i == 0) begin : g_first
         assign lft = '0;
         assign swl = 1'b0;
      end else begin : g_mid
         assign lft = cells[i-1];
         assign swl = sw[i-1];
      end
      if (i == QDEPTH - 1) begin : g_last
         assign rgt = '0;
      end else begin : g_next
         assign rgt = cells[i+1];
      end
      aprq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .idx          (IDX_W'(i)),
         .left         (lft),
         .right        (rgt),
         .sw_from_left (swl),
         .sw_right     (sw[i]),
         .q            (cells[i])
      );
      assign cell_vld[i] = cells[i].valid;
   end

   assign any_swap = |sw;

   // record of a process already queued; all its entries carry the same copy
   always_comb begin
      lk_or = '0;
      for (int i = 0; i < QDEPTH; i++) begin
         if (cells[i].valid && cells[i].pid == pid_ff) begin
            lk_or = lk_or | {cells[i].wait_cnt, cells[i].dups};
         end
      end
   end

   // ---- per-process statistics ----
   assign ram_raddr = (req_port.opcode == OP_PUSH) ? req_port.process_id : cells[0].pid;
   assign ram_we    = (state_ff == S_LOOK) || (state_ff == S_POP);
   assign ram_waddr = (state_ff == S_LOOK) ? pid_ff : cells[0].pid;
   assign st        = rd_vld_ff ? stat_type'(ram_rdata) : STAT_RESET;
   assign sum_ext   = {1'b0, st.sum} + (SUM_W+1)'(head_wait);

   always_comb begin
      st_wr = st;
      if (state_ff == S_LOOK) begin
         if (st.entries != '1) begin
            st_wr.entries = st.entries + 1'b1;
         end
      end else begin
         st_wr.wmin = (st.wmin > head_wait) ? head_wait : st.wmin;
         st_wr.wmax = (st.wmax < head_wait) ? head_wait : st.wmax;
         st_wr.sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
   end

   aprq_ram #(.WIDTH(STAT_W), .DEPTH(NUM_PROC)) u_stat_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (st_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      quiet_in = quiet_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_port.opcode)
                  OP_PUSH: state_in = (count_ff == CNT_W'(QDEPTH)) ? S_DONE : S_LOOK;
                  OP_POP:  state_in = (count_ff == '0) ? S_DONE : S_POP;
                  OP_TICK: state_in = S_TICK;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LOOK: state_in = S_PUSH;
         S_PUSH: begin
            count_in = count_ff + 1'b1;
            phase_in = 1'b0;
            quiet_in = 1'b0;
            state_in = S_SORT;
         end
         S_TICK: begin
            phase_in = 1'b0;
            quiet_in = 1'b0;
            state_in = S_SORT;
         end
         S_SORT: begin
            phase_in = !phase_ff;
            // two quiet phases in a row cover every neighbour pair
            if (any_swap) begin
               quiet_in = 1'b0;
            end else if (quiet_ff) begin
               state_in = S_DONE;
            end else begin
               quiet_in = 1'b1;
            end
         end
         S_POP: begin
            count_in = count_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         quiet_ff     <= 1'b0;
         thr_ff       <= WAIT_BITS'(10);
         rsp_valid_ff <= 1'b0;
         stat_vld_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         quiet_ff <= quiet_in;
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            stat_vld_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= stat_vld_ff[ram_raddr];
      if (accept) begin
         pid_ff        <= req_port.process_id;
         bp_ff         <= req_port.base_priority;
         res_pid_ff    <= '0;
         res_wait_ff   <= '0;
         res_min_ff    <= '0;
         res_max_ff    <= '0;
         res_sum_ff    <= '0;
         res_cnt_ff    <= '0;
         res_status_ff <= ST_OK;
         if (req_port.opcode == OP_PUSH && count_ff == CNT_W'(QDEPTH)) begin
            res_status_ff <= ST_FULL;
         end else if (req_port.opcode == OP_POP && count_ff == '0) begin
            res_status_ff <= ST_EMPTY;
         end
      end
      if (state_ff == S_LOOK) begin
         {lk_wait_ff, lk_dups_ff} <= lk_or;
      end
      if (state_ff == S_POP) begin
         res_pid_ff  <= cells[0].pid;
         res_wait_ff <= head_wait;
         res_min_ff  <= st_wr.wmin;
         res_max_ff  <= st_wr.wmax;
         res_sum_ff  <= st_wr.sum;
         res_cnt_ff  <= st.entries;
      end
      if (load_rsp) begin
         rsp_port.status       <= res_status_ff;
         rsp_port.cpu_process  <= res_pid_ff;
         rsp_port.wait_time    <= res_wait_ff;
         rsp_port.wait_min     <= res_min_ff;
         rsp_port.wait_max     <= res_max_ff;
         rsp_port.wait_sum     <= res_sum_ff;
         rsp_port.wait_count   <= res_cnt_ff;
         rsp_port.queue_length <= count_ff;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_row_matches_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(cell_vld) == int'(count_ff))
      else $error("occupied cells disagree with queue count");

   a_sort_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SORT && !any_swap && quiet_ff |=> state_ff == S_DONE)
      else $error("sort did not finish after two quiet phases");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> cells[0].valid)
      else $error("pop with empty head cell");

endmodule
`default_nettype wire

// ===== hw/rtl/aprq_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module aprq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/aprq_cell.sv =====
// One slot of the ready queue row: holds an entry, ages it, shifts and swaps it.
// Depends on aprq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aprq_cell import aprq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctl_type          ctl,
   input  wire logic [IDX_W-1:0] idx,
   input  wire cell_type         left,
   input  wire cell_type         right,
   input  wire logic             sw_from_left,
   output logic                  sw_right,
   output cell_type              q
);
   cell_type q_ff, q_in;
   logic [WAIT_BITS:0] wsum;
   logic [CNT_W-1:0]   steps;
   logic [KEY_W+CNT_W-1:0] csum;
   cell_type nx;

   assign q = q_ff;

   // left member of a compare pair swaps when its key is strictly lower (keeps it stable)
   assign sw_right = (ctl.cmd == CMD_SORT) && (idx[0] == ctl.phase) && q_ff.valid
                     && right.valid && (q_ff.cur < right.cur);

   // tick: all dup entries of a process step the shared wait, so apply dups steps at once
   always_comb begin
      wsum  = {1'b0, q_ff.wait_cnt} + (WAIT_BITS+1)'(q_ff.dups);
      steps = '0;
      if (ctl.thr == WAIT_MAX) begin
         if (q_ff.wait_cnt == WAIT_MAX) begin
            steps = q_ff.dups;
         end else if (wsum >= {1'b0, WAIT_MAX}) begin
            steps = CNT_W'(wsum - {1'b0, WAIT_MAX} + 1'b1);
         end
      end else if ((q_ff.wait_cnt < ctl.thr) && ({1'b0, ctl.thr} <= wsum)) begin
         steps = CNT_W'(1);
      end
      if (q_ff.base >= BASE_LIMIT) begin
         steps = '0;
      end
      csum = (KEY_W+CNT_W)'(q_ff.cur) + (KEY_W+CNT_W)'(steps);
   end

   always_comb begin
      q_in = q_ff;
      nx   = right;
      case (ctl.cmd)
         CMD_PUSH: begin
            if (q_ff.valid && q_ff.pid == ctl.pid) begin
               q_in.cur  = {1'b0, ctl.bp};
               q_in.base = ctl.bp;
               q_in.dups = q_ff.dups + 1'b1;
            end
            if ({1'b0, idx} == ctl.count) begin
               q_in.valid    = 1'b1;
               q_in.pid      = ctl.pid;
               q_in.wait_cnt = ctl.lk_wait;
               q_in.cur      = {1'b0, ctl.bp};
               q_in.base     = ctl.bp;
               q_in.dups     = ctl.lk_dups + 1'b1;
            end
         end
         CMD_POP: begin
            if (nx.valid && nx.pid == ctl.pop_pid) begin
               nx.wait_cnt = '0;
               nx.cur      = {1'b0, nx.base};
               nx.dups     = nx.dups - 1'b1;
            end
            q_in = nx;
         end
         CMD_TICK: begin
            if (q_ff.valid) begin
               q_in.wait_cnt = wsum[WAIT_BITS] ? WAIT_MAX : wsum[WAIT_BITS-1:0];
               q_in.cur      = (csum > (KEY_W+CNT_W)'(KEY_MAX)) ? KEY_MAX : csum[KEY_W-1:0];
            end
         end
         CMD_SORT: begin
            if (sw_right) begin
               q_in = right;
            end else if (sw_from_left) begin
               q_in = left;
            end
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end
endmodule
`default_nettype wire

// ===== sim/tb_aprq_if.sv =====
// Testbench-side note: the block's own interfaces aprq_req_if and aprq_rsp_if are
// reused as they stand; this file holds the stimulus and response record types only.
// Depends on aprq_pkg.
`timescale 1ns / 1ps
package tb_aprq_types;
   import aprq_pkg::*;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [PID_W-1:0]  process_id;
      logic [BASE_W-1:0] base_priority;
   } sched_cmd_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [PID_W-1:0]     cpu_process;
      logic [WAIT_BITS-1:0] wait_time;
      logic [WAIT_BITS-1:0] wait_min;
      logic [WAIT_BITS-1:0] wait_max;
      logic [SUM_W-1:0]     wait_sum;
      logic [ECNT_W-1:0]    wait_count;
      logic [CNT_W-1:0]     queue_length;
   } sched_rsp_type;
endpackage

// ===== sim/tb_aging_priority_ready_queue_unit.sv =====
// Testbench for aging_priority_ready_queue_unit: directed table, fill to full, then random
// push, pop, tick and unused words, checked against a behavioural scheduler model with random gaps.
// Depends on aprq_pkg, tb_aprq_types, aprq_req_if, aprq_rsp_if and the block.
`timescale 1ns / 1ps
module tb_aging_priority_ready_queue_unit;
   import aprq_pkg::*;
   import tb_aprq_types::*;

   localparam int LIMIT_CYCLES = 1500000;

   typedef struct {
      sched_cmd_type cmd;
      bit         has_exp;
      logic [1:0] exp_status;
      logic [CNT_W-1:0] exp_len;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [WAIT_BITS-1:0] csr_write_data = '0;

   aprq_req_if req_if ();
   aprq_rsp_if rsp_if ();

   aging_priority_ready_queue_unit i_dut (
      .clock(clock), .reset(reset), .req_port(req_if.sink), .rsp_port(rsp_if.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // scheduler model state
   logic [WAIT_BITS-1:0] m_thresh;
   logic [PID_W-1:0]     m_order[QDEPTH];
   int                   m_count;
   logic [WAIT_BITS-1:0] m_wait[NUM_PROC];
   logic [KEY_W-1:0]     m_cur[NUM_PROC];
   logic [BASE_W-1:0]    m_base[NUM_PROC];
   logic [WAIT_BITS-1:0] m_wmin[NUM_PROC];
   logic [WAIT_BITS-1:0] m_wmax[NUM_PROC];
   logic [SUM_W-1:0]     m_wsum[NUM_PROC];
   logic [ECNT_W-1:0]    m_entries[NUM_PROC];

   sched_rsp_type expected_rsps[$];
   int  fails = 0;
   longint cycles = 0;
   bit  rsp_hold_ok = 0;

   function automatic void sched_reset();
      m_thresh = 16'd10;
      m_count  = 0;
      for (int p = 0; p < NUM_PROC; p++) begin
         m_wait[p] = '0; m_cur[p] = '0; m_base[p] = '0;
         m_wmin[p] = WAIT_MAX; m_wmax[p] = '0; m_wsum[p] = '0; m_entries[p] = '0;
      end
   endfunction

   function automatic void sched_sort();
      logic [PID_W-1:0] it;
      int j;
      for (int i = 1; i < m_count; i++) begin
         it = m_order[i];
         j = i;
         while (j > 0 && m_cur[m_order[j-1]] < m_cur[it]) begin
            m_order[j] = m_order[j-1];
            j--;
         end
         m_order[j] = it;
      end
   endfunction

   function automatic sched_rsp_type sched_apply(sched_cmd_type c);
      sched_rsp_type r;
      logic [PID_W-1:0] pid;
      logic [WAIT_BITS-1:0] w;
      logic [SUM_W:0] s;
      r = '0;
      r.status = ST_OK;
      case (c.opcode)
         OP_PUSH: begin
            if (m_count >= QDEPTH) r.status = ST_FULL;
            else begin
               pid = c.process_id;
               m_order[m_count] = pid;
               m_count++;
               m_base[pid] = c.base_priority;
               m_cur[pid]  = c.base_priority;
               if (m_entries[pid] != '1) m_entries[pid]++;
               sched_sort();
            end
         end
         OP_POP: begin
            if (m_count == 0) r.status = ST_EMPTY;
            else begin
               pid = m_order[0];
               w = m_wait[pid];
               if (m_wmin[pid] > w) m_wmin[pid] = w;
               if (m_wmax[pid] < w) m_wmax[pid] = w;
               s = m_wsum[pid] + w;
               m_wsum[pid] = s[SUM_W] ? '1 : s[SUM_W-1:0];
               m_wait[pid] = '0;
               m_cur[pid] = m_base[pid];
               for (int i = 1; i < m_count; i++) m_order[i-1] = m_order[i];
               m_count--;
               r.cpu_process = pid; r.wait_time = w;
               r.wait_min = m_wmin[pid]; r.wait_max = m_wmax[pid];
               r.wait_sum = m_wsum[pid]; r.wait_count = m_entries[pid];
            end
         end
         OP_TICK: begin
            for (int i = 0; i < m_count; i++) begin
               pid = m_order[i];
               if (m_wait[pid] != WAIT_MAX) m_wait[pid]++;
               if (m_wait[pid] == m_thresh && m_base[pid] < BASE_LIMIT &&
                   m_cur[pid] != KEY_MAX)
                  m_cur[pid]++;
            end
            sched_sort();
         end
         default: ;
      endcase
      r.queue_length = m_count[CNT_W-1:0];
      return r;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // valid stays up after a handshake until the next word or a gap starts
   task automatic send_word(sched_cmd_type c);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= c.opcode;
      req_if.process_id <= c.process_id;
      req_if.base_priority <= c.base_priority;
      do @(posedge clock); while (!req_if.ready);
      expected_rsps.push_back(sched_apply(c));
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_threshold(logic [WAIT_BITS-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      m_thresh = v;
   endtask

   function automatic sched_cmd_type rand_cmd(int pid_hi, int push_w, int pop_w);
      sched_cmd_type c;
      int k;
      k = $urandom_range(0, 99);
      c.process_id = PID_W'($urandom_range(0, pid_hi));
      c.base_priority = BASE_W'($urandom_range(0, 15));
      if (k < push_w) c.opcode = OP_PUSH;
      else if (k < push_w + pop_w) c.opcode = OP_POP;
      else if (k < 98) c.opcode = OP_TICK;
      else c.opcode = 2'd3;
      return c;
   endfunction

   // result checking
   always @(posedge clock) begin
      sched_rsp_type e;
      cycles++;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result word");
            fails++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_if.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_if.status); fails++; end
            if (rsp_if.cpu_process !== e.cpu_process) begin
               $error("cpu_process exp %0d got %0d", e.cpu_process, rsp_if.cpu_process);
               fails++; end
            if (rsp_if.wait_time !== e.wait_time) begin
               $error("wait_time exp %0d got %0d", e.wait_time, rsp_if.wait_time);
               fails++; end
            if (rsp_if.wait_min !== e.wait_min) begin
               $error("wait_min exp %0d got %0d", e.wait_min, rsp_if.wait_min); fails++; end
            if (rsp_if.wait_max !== e.wait_max) begin
               $error("wait_max exp %0d got %0d", e.wait_max, rsp_if.wait_max); fails++; end
            if (rsp_if.wait_sum !== e.wait_sum) begin
               $error("wait_sum exp %0d got %0d", e.wait_sum, rsp_if.wait_sum); fails++; end
            if (rsp_if.wait_count !== e.wait_count) begin
               $error("wait_count exp %0d got %0d", e.wait_count, rsp_if.wait_count);
               fails++; end
            if (rsp_if.queue_length !== e.queue_length) begin
               $error("queue_length exp %0d got %0d", e.queue_length,
                      rsp_if.queue_length);
               fails++; end
         end
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result-side stalls
   initial begin
      int g;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_ok || $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end else begin
            g = gap_len();
            rsp_if.ready <= (g == 0);
            repeat (g > 0 ? g : 1) @(negedge clock);
         end
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      dir_row_type row;
      sched_cmd_type c;
      logic [WAIT_BITS-1:0] thr_set[5];
      int pid_hi;

      req_if.valid = 1'b0;
      req_if.opcode = OP_TICK;
      req_if.process_id = '0;
      req_if.base_priority = '0;
      sched_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows: empty pop, extremes, ties, aging, duplicates, unused opcode
      dir_rows.push_back('{'{OP_POP, 6'd0, 4'd0}, 1, ST_EMPTY, 7'd0});
      dir_rows.push_back('{'{OP_TICK, 6'd0, 4'd0}, 1, ST_OK, 7'd0});
      dir_rows.push_back('{'{2'd3, 6'd63, 4'd15}, 1, ST_OK, 7'd0});
      dir_rows.push_back('{'{OP_PUSH, 6'd63, 4'd15}, 1, ST_OK, 7'd1});
      dir_rows.push_back('{'{OP_PUSH, 6'd0, 4'd0}, 1, ST_OK, 7'd2});
      dir_rows.push_back('{'{OP_PUSH, 6'd21, 4'd0}, 0, ST_OK, 0});
      dir_rows.push_back('{'{OP_PUSH, 6'd42, 4'd10}, 0, ST_OK, 0});
      dir_rows.push_back('{'{OP_PUSH, 6'd42, 4'd5}, 0, ST_OK, 0});
      for (int i = 0; i < 12; i++) dir_rows.push_back('{'{OP_TICK, 6'd0, 4'd0}, 0, ST_OK, 0});
      for (int i = 0; i < 6; i++) dir_rows.push_back('{'{OP_POP, 6'd0, 4'd0}, 0, ST_OK, 0});
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_word(row.cmd);
         if (row.has_exp) begin
            expected_rsps[$].status = row.exp_status;
            expected_rsps[$].queue_length = row.exp_len;
         end
      end

      // fill to full and push once more
      set_threshold(16'd1);
      for (int i = 0; i < QDEPTH; i++) begin
         c.opcode = OP_PUSH; c.process_id = PID_W'(i);
         c.base_priority = BASE_W'($urandom_range(0, 15));
         send_word(c);
      end
      c.process_id = 6'd7;
      send_word(c);
      expected_rsps[$].status = ST_FULL;
      expected_rsps[$].queue_length = 7'd64;
      for (int i = 0; i < 3; i++) begin c.opcode = OP_TICK; send_word(c); end
      for (int i = 0; i < QDEPTH; i++) begin c.opcode = OP_POP; send_word(c); end

      // random phases over several thresholds
      thr_set = '{16'd0, 16'd3, 16'd10, 16'd2, 16'hFFFF};
      for (int ph = 0; ph < 5; ph++) begin
         set_threshold(thr_set[ph]);
         rsp_hold_ok = (ph == 2);
         pid_hi = (ph % 2) ? 7 : 63;
         for (int n = 0; n < 90; n++) begin
            if (n < 45) c = rand_cmd(pid_hi, 45, 20);
            else c = rand_cmd(pid_hi, 25, 35);
            send_word(c);
         end
      end
      rsp_hold_ok = 0;

      drain();
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
